[rtl/keyed_table_insert_delete_top_defines.svh]
// Assertion macros shared by the top level.
`ifndef KEYED_TABLE_INSERT_DELETE_TOP_DEFINES_SVH
`define KEYED_TABLE_INSERT_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define KTID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KTID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ktid_pkg.sv]
`timescale 1ns / 1ps

package ktid_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int OCC_W    = 7;

    localparam int IN_BITS  = OP_W + 4 * WORD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + SLOT_W + 3 * WORD_W + OCC_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] qty;
        logic [WORD_W-1:0] price;
        logic [WORD_W-1:0] key;
    } entry_t;

    typedef enum logic [2:0] {
        RES_FULL,
        RES_NOT_FOUND,
        RES_INSERT,
        RES_UPDATE,
        RES_HIT
    } res_kind_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INSERT,
        WR_UPDATE,
        WR_SHIFT
    } wr_kind_t;

    typedef struct packed {
        logic      load;
        logic      idx_inc;
        logic      rd_en;
        logic      rd_next;
        wr_kind_t  wr_kind;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_end;
        logic            shift_end;
        logic            full;
        logic            empty;
        logic            hit;
        logic            res_last;
        logic            out_free;
    } dp_stat_t;

endpackage

[rtl/ktid_ctrl.sv]
`timescale 1ns / 1ps

module ktid_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ktid_pkg::dp_stat_t stat,
    output ktid_pkg::dp_cmd_t  cmd
);
    import ktid_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DISPATCH  = 9'b000000010,
        ST_SRCH_RD   = 9'b000000100,
        ST_SRCH_CMP  = 9'b000001000,
        ST_SHIFT_RD  = 9'b000010000,
        ST_SHIFT_WR  = 9'b000100000,
        ST_LIST_RD   = 9'b001000000,
        ST_LIST_CAP  = 9'b010000000,
        ST_OUT       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_kind  = WR_NONE;
        cmd.res_kind = RES_HIT;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.op)
                    OP_INSERT: begin
                        if (stat.full) begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = RES_FULL;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_SRCH_RD;
                        end
                    end
                    OP_UPDATE, OP_LOOKUP, OP_DELETE: state_next = ST_SRCH_RD;
                    OP_LIST: begin
                        if (stat.empty) begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = RES_NOT_FOUND;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_LIST_RD;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SRCH_RD: begin
                if (stat.idx_end) begin
                    cmd.res_set = 1'b1;
                    if (stat.op == OP_INSERT) begin
                        cmd.wr_kind  = WR_INSERT;
                        cmd.cnt_inc  = 1'b1;
                        cmd.res_kind = RES_INSERT;
                    end else begin
                        cmd.res_kind = RES_NOT_FOUND;
                    end
                    state_next = ST_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (stat.hit) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_HIT;
                    state_next   = ST_OUT;
                    if (stat.op == OP_UPDATE) begin
                        cmd.wr_kind  = WR_UPDATE;
                        cmd.res_kind = RES_UPDATE;
                    end else if (stat.op == OP_DELETE) begin
                        state_next = ST_SHIFT_RD;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (stat.shift_end) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.wr_kind = WR_SHIFT;
                cmd.idx_inc = 1'b1;
                state_next  = ST_SHIFT_RD;
            end
            ST_LIST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LIST_CAP;
            end
            ST_LIST_CAP: begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_HIT;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.op == OP_LIST && !stat.res_last) begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_LIST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/ktid_dp.sv]
`timescale 1ns / 1ps

module ktid_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ktid_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ktid_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast,
    input  ktid_pkg::dp_cmd_t           cmd,
    output ktid_pkg::dp_stat_t          stat
);
    import ktid_pkg::*;

    entry_t mem [CAPACITY];

    logic [OP_W-1:0]     op_reg;
    logic [WORD_W-1:0]   skey_reg;
    logic [WORD_W-1:0]   rkey_reg;
    logic [WORD_W-1:0]   price_reg;
    logic [WORD_W-1:0]   qty_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    entry_t              rdata_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    entry_t              res_entry_reg;
    logic                res_last_reg;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tlast_reg;

    logic [CNT_W-1:0]    idx_plus1;
    logic [ADDR_W-1:0]   raddr;
    logic                wr_en;
    logic [ADDR_W-1:0]   waddr;
    entry_t              wdata;
    logic                hit_last;

    assign idx_plus1 = idx_reg + CNT_W'(1);
    assign raddr     = cmd.rd_next ? idx_plus1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign hit_last  = (op_reg != OP_LIST) || (idx_plus1 == cnt_reg);

    always_comb begin
        wr_en = 1'b1;
        waddr = idx_reg[ADDR_W-1:0];
        wdata = rdata_reg;
        case (cmd.wr_kind)
            WR_INSERT: begin
                waddr = cnt_reg[ADDR_W-1:0];
                wdata = '{qty: qty_reg, price: price_reg, key: skey_reg};
            end
            WR_UPDATE: wdata = '{qty: qty_reg, price: price_reg, key: rkey_reg};
            WR_SHIFT:  wdata = rdata_reg;
            default:   wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Captured transaction and walk index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tdata[OP_W-1:0];
            skey_reg  <= s_tdata[OP_W +: WORD_W];
            rkey_reg  <= s_tdata[OP_W + WORD_W +: WORD_W];
            price_reg <= s_tdata[OP_W + 2*WORD_W +: WORD_W];
            qty_reg   <= s_tdata[OP_W + 3*WORD_W +: WORD_W];
            idx_reg   <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_plus1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            case (cmd.res_kind)
                RES_FULL: begin
                    res_status_reg <= ST_FULL;
                    res_slot_reg   <= '0;
                    res_entry_reg  <= '0;
                    res_last_reg   <= 1'b1;
                end
                RES_NOT_FOUND: begin
                    res_status_reg <= ST_NOT_FOUND;
                    res_slot_reg   <= '0;
                    res_entry_reg  <= '0;
                    res_last_reg   <= 1'b1;
                end
                RES_INSERT: begin
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= SLOT_W'(cnt_reg);
                    res_entry_reg  <= '{qty: qty_reg, price: price_reg, key: skey_reg};
                    res_last_reg   <= 1'b1;
                end
                RES_UPDATE: begin
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= SLOT_W'(idx_reg);
                    res_entry_reg  <= '{qty: qty_reg, price: price_reg, key: rkey_reg};
                    res_last_reg   <= 1'b1;
                end
                default: begin
                    // existing entry: duplicate on insert, otherwise found
                    res_status_reg <= (op_reg == OP_INSERT) ? ST_DUPLICATE : ST_OK;
                    res_slot_reg   <= SLOT_W'(idx_reg);
                    res_entry_reg  <= rdata_reg;
                    res_last_reg   <= hit_last;
                end
            endcase
        end
    end

    // Output register; occupancy is sampled after any count change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_W'({OCC_W'(cnt_reg), res_entry_reg.qty, res_entry_reg.price,
                                   res_entry_reg.key, res_slot_reg, res_status_reg});
            m_tlast_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat.op        = op_reg;
    assign stat.idx_end   = (idx_reg == cnt_reg);
    assign stat.shift_end = (idx_plus1 == cnt_reg);
    assign stat.full      = (cnt_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.hit       = (rdata_reg.key == skey_reg);
    assign stat.res_last  = res_last_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

endmodule

[rtl/keyed_table_insert_delete_top.sv]
`timescale 1ns / 1ps
// Channel   Ports                       Carries
// input     s_tvalid s_tready s_tdata   one operation: opcode, keys, price, quantity
// result    m_tvalid m_tready m_tdata   status, slot, entry, occupancy; m_tlast ends a run
//
// An operation is accepted in ST_IDLE and dispatched in ST_DISPATCH. The key search then
// reads and compares each entry in turn (ST_SRCH_RD, ST_SRCH_CMP; registered table read),
// and delete moves each later entry down (ST_SHIFT_RD, ST_SHIFT_WR).
// List reads, captures and outputs each entry in turn. One operation is in work at a time.
// Reset (aresetn low, synchronous) empties the table; no clearing pass is run.
// A stalled m_tready holds the result and pauses the walk before the next result.

module keyed_table_insert_delete_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // opcode, search_key, replacement_key, price_word, stock_quantity
    input  logic [ktid_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, slot, entry_key, entry_price, entry_quantity, occupancy
    output logic [ktid_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import ktid_pkg::*;

`include "keyed_table_insert_delete_top_defines.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ktid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ktid_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    `KTID_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `KTID_ASSERT_NOW(a_error_ends_run, m_tvalid && (m_tdata[1:0] != ST_OK), m_tlast, "error not last")
    `KTID_ASSERT_NOW(a_occ_bound, m_tvalid, m_tdata[110:104] <= OCC_W'(CAPACITY), "occupancy too high")
    `KTID_ASSERT_NOW(a_full_occ, m_tvalid && (m_tdata[1:0] == ST_FULL), m_tdata[110:104] == OCC_W'(CAPACITY), "full with room")

endmodule

[tb/keyed_table_insert_delete_top_test.sv]
`timescale 1ns / 1ps

module keyed_table_insert_delete_top_test;
    import ktid_pkg::*;

    // m_tdata field offsets, lowest first
    localparam int OFS_SLOT  = STATUS_W;
    localparam int OFS_KEY   = OFS_SLOT + SLOT_W;
    localparam int OFS_PRICE = OFS_KEY + WORD_W;
    localparam int OFS_QTY   = OFS_PRICE + WORD_W;
    localparam int OFS_OCC   = OFS_QTY + WORD_W;

    localparam int FIRST_SPARE_OP = 5;
    localparam int MAX_PRINTED    = 40;

    localparam logic [WORD_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   key;
        logic [WORD_W-1:0]   price;
        logic [WORD_W-1:0]   qty;
        logic [OCC_W-1:0]    occupancy;
        logic                last;
    } table_result_t;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // opcode, search_key, replacement_key, price_word, stock_quantity
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // status, slot, entry_key, entry_price, entry_quantity, occupancy
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    // mirror of the table contents
    logic [WORD_W-1:0] tbl_key   [CAPACITY];
    logic [WORD_W-1:0] tbl_price [CAPACITY];
    logic [WORD_W-1:0] tbl_qty   [CAPACITY];
    int                tbl_count = 0;

    table_result_t expected_results[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int ops_accepted    = 0;
    int n_full          = 0;
    int n_dup           = 0;
    int n_miss          = 0;
    int n_lists         = 0;
    int peak_occupancy  = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    logic [WORD_W-1:0] key_pool [12] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd100, 32'hFFFF_FF9C, 32'h8000_0001
    };

    keyed_table_insert_delete_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("keyed_table_insert_delete_top regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    endtask

    function automatic int find_slot(input logic [WORD_W-1:0] k);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_result(input logic [STATUS_W-1:0] status, input int slot,
                                        input logic [WORD_W-1:0] key,
                                        input logic [WORD_W-1:0] price,
                                        input logic [WORD_W-1:0] qty, input logic last);
        table_result_t r;
        r.status    = status;
        r.slot      = slot[SLOT_W-1:0];
        r.key       = key;
        r.price     = price;
        r.qty       = qty;
        r.occupancy = tbl_count[OCC_W-1:0];
        r.last      = last;
        case (status)
            ST_FULL:      n_full++;
            ST_DUPLICATE: n_dup++;
            ST_NOT_FOUND: n_miss++;
            default: ;
        endcase
        expected_results.push_back(r);
    endfunction

    // Works out the results of one accepted operation and updates the mirror.
    task automatic apply_table_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] skey,
                                  input logic [WORD_W-1:0] rkey,
                                  input logic [WORD_W-1:0] price,
                                  input logic [WORD_W-1:0] qty);
        int pos;
        logic [WORD_W-1:0] k_old, p_old, q_old;
        ops_accepted++;
        pos = find_slot(skey);
        case (op)
            OP_INSERT: begin
                // full is checked ahead of the duplicate search
                if (tbl_count >= CAPACITY) begin
                    push_result(ST_FULL, 0, '0, '0, '0, 1'b1);
                end else if (pos >= 0) begin
                    push_result(ST_DUPLICATE, pos, tbl_key[pos], tbl_price[pos],
                                tbl_qty[pos], 1'b1);
                end else begin
                    tbl_key[tbl_count]   = skey;
                    tbl_price[tbl_count] = price;
                    tbl_qty[tbl_count]   = qty;
                    tbl_count++;
                    push_result(ST_OK, tbl_count - 1, skey, price, qty, 1'b1);
                end
            end
            OP_UPDATE: begin
                if (pos < 0) begin
                    push_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
                end else begin
                    tbl_key[pos]   = rkey;
                    tbl_price[pos] = price;
                    tbl_qty[pos]   = qty;
                    push_result(ST_OK, pos, rkey, price, qty, 1'b1);
                end
            end
            OP_LOOKUP: begin
                if (pos < 0)
                    push_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
                else
                    push_result(ST_OK, pos, tbl_key[pos], tbl_price[pos], tbl_qty[pos], 1'b1);
            end
            OP_DELETE: begin
                if (pos < 0) begin
                    push_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
                end else begin
                    k_old = tbl_key[pos];
                    p_old = tbl_price[pos];
                    q_old = tbl_qty[pos];
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_key[i]   = tbl_key[i + 1];
                        tbl_price[i] = tbl_price[i + 1];
                        tbl_qty[i]   = tbl_qty[i + 1];
                    end
                    tbl_count--;
                    push_result(ST_OK, pos, k_old, p_old, q_old, 1'b1);
                end
            end
            OP_LIST: begin
                n_lists++;
                if (tbl_count == 0) begin
                    push_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < tbl_count; i++)
                        push_result(ST_OK, i, tbl_key[i], tbl_price[i], tbl_qty[i],
                                    i == tbl_count - 1);
                end
            end
            default: ;
        endcase
        if (tbl_count > peak_occupancy)
            peak_occupancy = tbl_count;
    endtask

    // Leaves tvalid high on return; wait_for_results or send_op idling drops it.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] skey,
                           input logic [WORD_W-1:0] rkey, input logic [WORD_W-1:0] price,
                           input logic [WORD_W-1:0] qty);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - IN_BITS){1'b0}}, qty, price, rkey, skey, op};
        do @(posedge aclk); while (!s_tready);
        apply_table_op(op, skey, rkey, price, qty);
    endtask

    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly keys that collide with the pool or the table, so searches hit.
    function automatic logic [WORD_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return key_pool[$urandom_range(0, 11)];
        if (sel < 8 && tbl_count > 0)
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] fresh_key();
        logic [WORD_W-1:0] k;
        do k = $urandom; while (find_slot(k) >= 0);
        return k;
    endfunction

    task automatic test_empty_table;
        send_op(OP_LIST, '0, '0, '0, '0);
        send_op(OP_LOOKUP, pick_key(), '0, '0, '0);
        send_op(OP_UPDATE, pick_key(), pick_key(), $urandom, $urandom);
        send_op(OP_DELETE, pick_key(), '0, '0, '0);
        // spare opcodes: ignored, no transaction back
        for (int op = FIRST_SPARE_OP; op < 2 ** OP_W; op++)
            send_op(op[OP_W-1:0], $urandom, $urandom, $urandom, $urandom);
        wait_for_results;
    endtask

    task automatic test_extreme_entries;
        send_op(OP_INSERT, KEY_MIN, '0, '0, KEY_MAX);
        send_op(OP_INSERT, KEY_MAX, '0, ALL_ONES, KEY_MIN);
        send_op(OP_INSERT, ALL_ONES, '0, $urandom, '0);
        send_op(OP_INSERT, KEY_MAX, $urandom, $urandom, $urandom);
        send_op(OP_LOOKUP, KEY_MIN, '0, '0, '0);
        // rename to a key already present: two slots now share it
        send_op(OP_UPDATE, ALL_ONES, KEY_MIN, '0, ALL_ONES);
        send_op(OP_LOOKUP, KEY_MIN, '0, '0, '0);
        send_op(OP_LIST, '0, '0, '0, '0);
        send_op(OP_DELETE, KEY_MIN, '0, '0, '0);
        send_op(OP_LOOKUP, KEY_MIN, '0, '0, '0);
        send_op(OP_UPDATE, KEY_MAX, KEY_MAX, $urandom, $urandom);
        send_op(OP_DELETE, KEY_MIN, '0, '0, '0);
        send_op(OP_LIST, '0, '0, '0, '0);
        wait_for_results;
    endtask

    task automatic test_fill_and_overflow;
        while (tbl_count < CAPACITY)
            send_op(OP_INSERT, fresh_key(), $urandom, $urandom, $urandom);
        send_op(OP_INSERT, fresh_key(), $urandom, $urandom, $urandom);
        send_op(OP_INSERT, tbl_key[0], $urandom, $urandom, $urandom);
        send_op(OP_LIST, '0, '0, '0, '0);
        send_op(OP_LOOKUP, tbl_key[CAPACITY - 1], '0, '0, '0);
        send_op(OP_UPDATE, tbl_key[CAPACITY - 1], fresh_key(), $urandom, $urandom);
        // slot 0 gives the longest shift
        send_op(OP_DELETE, tbl_key[0], '0, '0, '0);
        send_op(OP_DELETE, tbl_key[tbl_count - 1], '0, '0, '0);
        send_op(OP_INSERT, fresh_key(), $urandom, $urandom, $urandom);
        wait_for_results;
    endtask

    task automatic test_random_ops(input int n, input int ins_pct, input int del_pct);
        int sent;
        int sel;
        logic [OP_W-1:0] op;
        logic [WORD_W-1:0] skey;
        sent = 0;
        while (sent < n) begin
            sel = $urandom_range(0, 99);
            if (sel < ins_pct)
                op = OP_INSERT;
            else if (sel < ins_pct + 15)
                op = OP_UPDATE;
            else if (sel < ins_pct + 33)
                op = OP_LOOKUP;
            else if (sel < ins_pct + 33 + del_pct)
                op = OP_DELETE;
            else if (sel < ins_pct + 39 + del_pct)
                op = OP_LIST;
            else
                op = OP_W'($urandom_range(FIRST_SPARE_OP, 2 ** OP_W - 1));
            if (op == OP_INSERT && $urandom_range(0, 1))
                skey = fresh_key();
            else
                skey = pick_key();
            send_op(op, skey, pick_key(), $urandom, $urandom);
            if (op <= OP_LIST)
                sent++;
        end
        wait_for_results;
    endtask

    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with none outstanding",
                                m_tdata[OFS_KEY +: WORD_W], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0 +: STATUS_W] !== want.status)
                    report_mismatch("status", WORD_W'(m_tdata[0 +: STATUS_W]),
                                    WORD_W'(want.status));
                if (m_tdata[OFS_SLOT +: SLOT_W] !== want.slot)
                    report_mismatch("slot", WORD_W'(m_tdata[OFS_SLOT +: SLOT_W]),
                                    WORD_W'(want.slot));
                if (m_tdata[OFS_KEY +: WORD_W] !== want.key)
                    report_mismatch("entry_key", m_tdata[OFS_KEY +: WORD_W], want.key);
                if (m_tdata[OFS_PRICE +: WORD_W] !== want.price)
                    report_mismatch("entry_price", m_tdata[OFS_PRICE +: WORD_W], want.price);
                if (m_tdata[OFS_QTY +: WORD_W] !== want.qty)
                    report_mismatch("entry_quantity", m_tdata[OFS_QTY +: WORD_W], want.qty);
                if (m_tdata[OFS_OCC +: OCC_W] !== want.occupancy)
                    report_mismatch("occupancy", WORD_W'(m_tdata[OFS_OCC +: OCC_W]),
                                    WORD_W'(want.occupancy));
                if (m_tlast !== want.last)
                    report_mismatch("tlast", WORD_W'(m_tlast), WORD_W'(want.last));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(8, 63);
        test_empty_table;
        test_extreme_entries;
        test_fill_and_overflow;
        test_random_ops(70, 20, 37);

        set_idling(63, 8);
        test_random_ops(70, 30, 27);

        set_idling(0, 0);
        test_random_ops(70, 40, 17);

        repeat (4 * CAPACITY + 16) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", WORD_W'(expected_results.size()), '0);

        $display("%0d operations sent, %0d result transactions checked, %0d lists",
                 ops_accepted, results_checked, n_lists);
        $display("outcomes: %0d full, %0d duplicate, %0d not found; peak occupancy %0d",
                 n_full, n_dup, n_miss, peak_occupancy);
        if (mismatch_count == 0)
            $display("keyed_table_insert_delete_top regression: pass");
        else
            $display("keyed_table_insert_delete_top regression: fail");
        $finish;
    end

endmodule
